>>> rtl/lz_2d_rgb_image_decompressor_core_assert.svh
// assertion macros used by the decompressor core
`ifndef LZ_2D_RGB_IMAGE_DECOMPRESSOR_CORE_ASSERT_SVH
`define LZ_2D_RGB_IMAGE_DECOMPRESSOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// condition implies consequence in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed: same-cycle implication");
// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

>>> rtl/lz2drgb_pkg.sv
package lz2drgb_pkg;

	// history ring geometry
	localparam int HIST_DEPTH = 16384;
	localparam int HIST_AW = $clog2(HIST_DEPTH);
	// backward distance holds 0 .. HIST_DEPTH
	localparam int DIST_W = HIST_AW + 1;

	localparam int WC_W = 24;
	localparam int RUN_W = 18;
	localparam int WIDTH_W = 11;

	localparam logic [WC_W-1:0] HEADER_BYTES = 24'd3;
	localparam logic [7:0] TOKEN_COPY_MIN = 8'h80;
	localparam logic [7:0] TOKEN_LIT_LONG = 8'h7f;
	localparam logic [1:0] COPY_LEN_LONG = 2'd3;

	// request commands
	localparam logic CMD_FEED = 1'b0;
	localparam logic CMD_PULL = 1'b1;

	// configuration register indexes
	localparam logic [7:0] REG_IMAGE_WIDTH = 8'd0;
	localparam logic [7:0] REG_OUTPUT_LENGTH = 8'd1;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_TOKEN = 3'd1,
		PH_LEN_LO = 3'd2,
		PH_LEN_HI = 3'd3,
		PH_LITERAL = 3'd4,
		PH_COPY = 3'd5,
		PH_DONE = 3'd6,
		PH_ERROR = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		K_NONE = 2'd0,
		K_DATA = 2'd1,
		K_DONE = 2'd2,
		K_ERR = 2'd3
	} kind_t;

	// x * 3 as shift and add
	function automatic logic [RUN_W-1:0] times3(input logic [RUN_W-1:0] x);
		return x + {x[RUN_W-2:0], 1'b0};
	endfunction

	// backward distance for an offset index, 0 when the target reads zero
	function automatic logic [DIST_W-1:0] offset_dist(input logic [4:0] idx,
		input logic [WIDTH_W-1:0] w);
		int i;
		int wi;
		int off;
		i = int'(idx);
		wi = int'(w);
		if (i < 6) begin
			off = -3 * (i + 1);
		end else if (i < 13) begin
			off = 3 * (9 - i) - 3 * wi;
		end else if (i < 20) begin
			off = 3 * (16 - i) - 6 * wi;
		end else if (i < 27) begin
			off = 3 * (23 - i) - 9 * wi;
		end else begin
			off = 3 * (29 - i) - 12 * wi;
		end
		if (off >= 0 || -off > HIST_DEPTH) begin
			return '0;
		end
		return DIST_W'(-off);
	endfunction

endpackage

>>> rtl/lz_2d_rgb_image_decompressor_core.sv
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/s_axis_tready tdata in_byte, tuser command, tlast in_last
// m_axis    out  m_axis_tvalid/m_axis_tready tdata out_byte, tuser kind, tlast out_last
// cfg       in   cfg_valid/cfg_ready         cfg_index register, cfg_data value
//
// one request accepted per cycle while the output register is empty or being drained, one result
// per request, result valid the cycle after; the history ring is a single-port-write, single-port-read
// memory; a copy reads at least three bytes back, so the pending write never hits the address read
// reset clears all control state; history needs no clearing pass, never-written
// entries are never read
// a stalled result holds the input side only once the output register is full
`include "lz_2d_rgb_image_decompressor_core_assert.svh"

module lz_2d_rgb_image_decompressor_core
	import lz2drgb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic [0:0]  s_axis_tuser,   // [0] command
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	// decoder state
	phase_t               ph_q, ph_n;
	logic [WC_W-1:0]      wc_q, wc_n, wc_inc;
	logic [RUN_W-1:0]     run_q, run_n, run_dec, run_len;
	logic [7:0]           len_lo_q, len_lo_n;
	logic [5:0]           tok_q, tok_n;
	logic [DIST_W-1:0]    dist_q, dist_n;
	logic [WIDTH_W-1:0]   width_q;
	logic [WC_W-1:0]      olen_q;

	// output register and pending history write
	logic                 m_valid_q;
	kind_t                kind_q, kind_n;
	logic [7:0]           byte_q, byte_n;
	logic                 last_q, last_n;
	logic                 src_ram_q, src_ram_n;
	logic                 wr_en_q, wr_n;
	logic [HIST_AW-1:0]   wr_addr_q;

	logic                 in_acc;
	logic                 rd_en, rd_ok;
	logic [HIST_AW-1:0]   rd_addr;
	logic [7:0]           rd_data, res_byte;
	logic                 start_lit, start_copy;
	logic [4:0]           idx_sel;
	logic [15:0]          len_word;
	logic [WC_W-1:0]      left;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	assign wc_inc = wc_q + 24'd1;
	assign run_dec = run_q - 18'd1;
	assign len_word = {s_axis_tdata, len_lo_q};
	assign left = olen_q - wc_q;
	assign rd_ok = (dist_q != '0) && ({{(WC_W - DIST_W){1'b0}}, dist_q} <= wc_q);
	assign rd_addr = wc_q[HIST_AW-1:0] - dist_q[HIST_AW-1:0];

	// result byte comes from the registered read or the output register
	assign res_byte = src_ram_q ? rd_data : byte_q;

	// step of the decoder for the offered request
	always_comb begin
		ph_n = ph_q;
		wc_n = wc_q;
		run_n = run_q;
		len_lo_n = len_lo_q;
		tok_n = tok_q;
		dist_n = dist_q;
		kind_n = K_NONE;
		byte_n = '0;
		last_n = 1'b0;
		src_ram_n = 1'b0;
		wr_n = 1'b0;
		rd_en = 1'b0;
		start_lit = 1'b0;
		start_copy = 1'b0;
		run_len = '0;
		idx_sel = tok_q[4:0];
		if (ph_n != PH_DONE && ph_n != PH_ERROR && wc_q >= olen_q) begin
			ph_n = PH_DONE;
		end
		if (ph_n == PH_DONE) begin
			kind_n = K_DONE;
		end else if (ph_n == PH_ERROR) begin
			kind_n = K_ERR;
		end else if (s_axis_tuser[0] == CMD_PULL) begin
			// copy byte from history
			if (ph_n == PH_COPY) begin
				rd_en = rd_ok;
				src_ram_n = rd_ok;
				wr_n = 1'b1;
				wc_n = wc_inc;
				run_n = run_dec;
				kind_n = K_DATA;
				if (wc_inc >= olen_q) begin
					ph_n = PH_DONE;
					last_n = 1'b1;
				end else if (run_dec == '0) begin
					ph_n = PH_TOKEN;
				end
			end
		end else begin
			case (ph_n)
				PH_HEADER, PH_LITERAL: begin
					wr_n = 1'b1;
					wc_n = wc_inc;
					kind_n = K_DATA;
					byte_n = s_axis_tdata;
					if (ph_n == PH_LITERAL) begin
						run_n = run_dec;
					end
					if (wc_inc >= olen_q) begin
						ph_n = PH_DONE;
						last_n = 1'b1;
					end else if (s_axis_tlast) begin
						ph_n = PH_ERROR;
					end else if (ph_n == PH_HEADER && wc_inc >= HEADER_BYTES) begin
						ph_n = PH_TOKEN;
					end else if (ph_n == PH_LITERAL && run_dec == '0) begin
						ph_n = PH_TOKEN;
					end
				end
				PH_TOKEN: begin
					if (s_axis_tdata < TOKEN_COPY_MIN) begin
						tok_n = '0;
						if (s_axis_tdata != TOKEN_LIT_LONG) begin
							start_lit = 1'b1;
							run_len = times3({11'd0, s_axis_tdata[6:0]}) + 18'd3;
						end else begin
							ph_n = s_axis_tlast ? PH_ERROR : PH_LEN_LO;
						end
					end else begin
						tok_n = {1'b1, s_axis_tdata[6:2]};
						idx_sel = s_axis_tdata[6:2];
						if (s_axis_tdata[1:0] != COPY_LEN_LONG) begin
							start_copy = 1'b1;
							run_len = times3({16'd0, s_axis_tdata[1:0]}) + 18'd3;
						end else begin
							ph_n = s_axis_tlast ? PH_ERROR : PH_LEN_LO;
						end
					end
				end
				PH_LEN_LO: begin
					len_lo_n = s_axis_tdata;
					ph_n = s_axis_tlast ? PH_ERROR : PH_LEN_HI;
				end
				PH_LEN_HI: begin
					if (tok_q[5]) begin
						start_copy = 1'b1;
						run_len = times3({2'd0, len_word} + 18'd4);
					end else begin
						start_lit = 1'b1;
						run_len = times3({2'd0, len_word} + 18'd128);
					end
				end
				default: begin
				end
			endcase
			// start of a literal run
			if (start_lit) begin
				if (({1'b0, wc_q} + {7'd0, run_len}) > {1'b0, olen_q} || s_axis_tlast) begin
					ph_n = PH_ERROR;
				end else begin
					run_n = run_len;
					ph_n = PH_LITERAL;
				end
			end
			// start of a back-reference copy
			if (start_copy) begin
				if (s_axis_tlast && ({6'd0, run_len} < left)) begin
					ph_n = PH_ERROR;
				end else begin
					dist_n = offset_dist(idx_sel, width_q);
					run_n = run_len;
					ph_n = PH_COPY;
				end
			end
			if (ph_n == PH_ERROR) begin
				kind_n = K_ERR;
				byte_n = '0;
				last_n = 1'b0;
				src_ram_n = 1'b0;
			end
		end
	end

	// decoder state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_HEADER;
			wc_q <= '0;
			run_q <= '0;
			len_lo_q <= '0;
			tok_q <= '0;
			dist_q <= '0;
		end else if (in_acc) begin
			ph_q <= ph_n;
			wc_q <= wc_n;
			run_q <= run_n;
			len_lo_q <= len_lo_n;
			tok_q <= tok_n;
			dist_q <= dist_n;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd1;
			olen_q <= 24'd3;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_IMAGE_WIDTH) begin
				width_q <= cfg_data[WIDTH_W-1:0];
			end else if (cfg_index == REG_OUTPUT_LENGTH) begin
				olen_q <= cfg_data;
			end
		end
	end

	// output valid and pending write control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			wr_en_q <= 1'b0;
		end else begin
			wr_en_q <= in_acc && wr_n;
			if (in_acc) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// result payload and write address
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q <= kind_n;
			byte_q <= byte_n;
			last_q <= last_n;
			src_ram_q <= src_ram_n;
			wr_addr_q <= wc_q[HIST_AW-1:0];
		end
	end

	// history ring
	lz2drgb_ram #(
		.WIDTH(8),
		.DEPTH(HIST_DEPTH)
	) u_hist (
		.clk(clk),
		.we(wr_en_q),
		.waddr(wr_addr_q),
		.wdata(res_byte),
		.re(in_acc && rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = res_byte;
	assign m_axis_tuser = kind_q;
	assign m_axis_tlast = last_q;

	`ASSERT_IMPLY(a_no_rw_clash, clk, arst_n, wr_en_q && in_acc && rd_en, rd_addr != wr_addr_q)
	`ASSERT_IMPLY(a_wr_from_req, clk, arst_n, wr_en_q, $past(in_acc))
	`ASSERT_IMPLY(a_wc_step, clk, arst_n, wc_q != $past(wc_q), wc_q == $past(wc_q) + 24'd1)
	`ASSERT_NEXT(a_err_latch, clk, arst_n, ph_q == PH_ERROR, ph_q == PH_ERROR)
	`ASSERT_IMPLY(a_ram_src_data, clk, arst_n, m_valid_q && src_ram_q, kind_q == K_DATA)

endmodule

>>> rtl/lz2drgb_ram.sv
module lz2drgb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
